// ----- design/fbl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fbl_pkg;

	localparam int LEN_W     = 16;
	localparam int ANG_W     = 9;
	localparam int OUT_W     = 20;
	localparam int CRD_W     = LEN_W + 2;
	localparam int TRIG_W    = 17;
	localparam int PROD_W    = LEN_W + TRIG_W;
	localparam int SQR_W     = 2 * CRD_W;
	localparam int NA_W      = SQR_W + 1;
	localparam int RAD_W     = 36;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 1;
	localparam int SQ_CELLS  = RAD_W / 2;
	localparam int DIV_N_W   = 36;
	localparam int DIV_D_W   = ROOT_W + 1;
	localparam int DIV_CELLS = DIV_N_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CRANK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROCKER  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROUND  = 2'd3;

	localparam logic [1:0] ST_SOLVED     = 2'd0;
	localparam logic [1:0] ST_NO_MEET    = 2'd1;
	localparam logic [1:0] ST_COINCIDENT = 2'd2;

	typedef struct packed {
		logic [DIV_D_W-1:0] r;
		logic [DIV_N_W-1:0] n;
		logic [DIV_N_W-1:0] q;
		logic [DIV_D_W-1:0] d;
	} div_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [RAD_W-1:0]  rad;
		logic [ROOT_W-1:0] root;
	} sq_t;

	function automatic logic [TRIG_W-1:0] sin_lut(input logic [6:0] k);
		logic [TRIG_W-1:0] v;
		case (k)
			7'd0: v = 17'd0;         7'd1: v = 17'd1144;      7'd2: v = 17'd2287;
			7'd3: v = 17'd3430;      7'd4: v = 17'd4572;      7'd5: v = 17'd5712;
			7'd6: v = 17'd6850;      7'd7: v = 17'd7987;      7'd8: v = 17'd9121;
			7'd9: v = 17'd10252;     7'd10: v = 17'd11380;    7'd11: v = 17'd12505;
			7'd12: v = 17'd13626;    7'd13: v = 17'd14742;    7'd14: v = 17'd15855;
			7'd15: v = 17'd16962;    7'd16: v = 17'd18064;    7'd17: v = 17'd19161;
			7'd18: v = 17'd20252;    7'd19: v = 17'd21336;    7'd20: v = 17'd22415;
			7'd21: v = 17'd23486;    7'd22: v = 17'd24550;    7'd23: v = 17'd25607;
			7'd24: v = 17'd26656;    7'd25: v = 17'd27697;    7'd26: v = 17'd28729;
			7'd27: v = 17'd29753;    7'd28: v = 17'd30767;    7'd29: v = 17'd31773;
			7'd30: v = 17'd32768;    7'd31: v = 17'd33754;    7'd32: v = 17'd34729;
			7'd33: v = 17'd35693;    7'd34: v = 17'd36647;    7'd35: v = 17'd37590;
			7'd36: v = 17'd38521;    7'd37: v = 17'd39441;    7'd38: v = 17'd40348;
			7'd39: v = 17'd41243;    7'd40: v = 17'd42126;    7'd41: v = 17'd42995;
			7'd42: v = 17'd43852;    7'd43: v = 17'd44695;    7'd44: v = 17'd45525;
			7'd45: v = 17'd46341;    7'd46: v = 17'd47143;    7'd47: v = 17'd47930;
			7'd48: v = 17'd48703;    7'd49: v = 17'd49461;    7'd50: v = 17'd50203;
			7'd51: v = 17'd50931;    7'd52: v = 17'd51643;    7'd53: v = 17'd52339;
			7'd54: v = 17'd53020;    7'd55: v = 17'd53684;    7'd56: v = 17'd54332;
			7'd57: v = 17'd54963;    7'd58: v = 17'd55578;    7'd59: v = 17'd56175;
			7'd60: v = 17'd56756;    7'd61: v = 17'd57319;    7'd62: v = 17'd57865;
			7'd63: v = 17'd58393;    7'd64: v = 17'd58903;    7'd65: v = 17'd59396;
			7'd66: v = 17'd59870;    7'd67: v = 17'd60326;    7'd68: v = 17'd60764;
			7'd69: v = 17'd61183;    7'd70: v = 17'd61584;    7'd71: v = 17'd61966;
			7'd72: v = 17'd62328;    7'd73: v = 17'd62672;    7'd74: v = 17'd62997;
			7'd75: v = 17'd63303;    7'd76: v = 17'd63589;    7'd77: v = 17'd63856;
			7'd78: v = 17'd64104;    7'd79: v = 17'd64332;    7'd80: v = 17'd64540;
			7'd81: v = 17'd64729;    7'd82: v = 17'd64898;    7'd83: v = 17'd65048;
			7'd84: v = 17'd65177;    7'd85: v = 17'd65287;    7'd86: v = 17'd65376;
			7'd87: v = 17'd65446;    7'd88: v = 17'd65496;    7'd89: v = 17'd65526;
			7'd90: v = 17'd65536;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- design/fbl_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbl_sqrt_cell import fbl_pkg::*; (
	input  logic clk,
	input  logic en,
	input  sq_t  d_in,
	output sq_t  d_out
);

	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] test;
	logic [REM_W+1:0] diff;
	logic             ge;
	sq_t              d_q;

	assign trial = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
	assign test  = {1'b0, d_in.root, 2'b01};
	assign diff  = trial - test;
	assign ge    = trial >= test;

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= '{rem:  ge ? diff[REM_W-1:0] : trial[REM_W-1:0],
			         rad:  {d_in.rad[RAD_W-3:0], 2'b00},
			         root: {d_in.root[ROOT_W-2:0], ge}};
		end
	end

	assign d_out = d_q;

endmodule

`default_nettype wire

// ----- design/fbl_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbl_div_cell import fbl_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	logic [DIV_D_W:0] trial;
	logic [DIV_D_W:0] diff;
	logic             ge;
	div_t             d_q;

	assign trial = {d_in.r, d_in.n[DIV_N_W-1]};
	assign diff  = trial - {1'b0, d_in.d};
	assign ge    = trial >= {1'b0, d_in.d};

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= '{r: ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0],
			         n: {d_in.n[DIV_N_W-2:0], 1'b0},
			         q: {d_in.q[DIV_N_W-2:0], ge},
			         d: d_in.d};
		end
	end

	assign d_out = d_q;

endmodule

`default_nettype wire

// ----- design/four_bar_linkage_position.sv -----
// Four-bar linkage position solver.
// Configuration: write crank_length, coupler_length, rocker_length and
// ground_distance (unsigned Q8.8) through cfg_we / cfg_index / cfg_data while
// no angle is in flight. All four clear to zero at reset.
// Input channel: angle_deg with angle_valid / angle_stall. One angle per cycle
// is taken; the block raises angle_stall only while its two-entry output
// buffer is full.
// Output channel: crank_x, crank_y, joint_x, joint_y (signed Q11.8) and status
// with result_valid / result_stall, one result per angle, in order.
// The path is a chain of one-bit restoring cells: an 18-cell square root for
// the pivot distance, a 36-cell divider for the chord offset, an 18-cell
// square root for the height and two 36-cell dividers for the joint offset,
// plus 18 arithmetic stages. One result per cycle leaves while result_stall is low.
// When the receiver stalls, the result holds; the pipeline keeps moving until
// the output buffer is full, then the whole pipeline holds.
// Reset (arst_n low, asynchronous) empties the pipeline and the buffer.
`timescale 1ns / 1ps
`default_nettype none

module four_bar_linkage_position import fbl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [LEN_W-1:0]         cfg_data,
	input  logic                     angle_valid,
	output logic                     angle_stall,
	input  logic [ANG_W-1:0]         angle_deg,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [OUT_W-1:0]  crank_x,
	output logic signed [OUT_W-1:0]  crank_y,
	output logic signed [OUT_W-1:0]  joint_x,
	output logic signed [OUT_W-1:0]  joint_y,
	output logic [1:0]               status
);

	localparam int SUM_W = DIV_N_W + 2;
	localparam int PM_W  = 2 * CRD_W;
	localparam int NX_W  = PM_W + 1;
	localparam logic [ANG_W-1:0] ANG_FULL = 9'd360;
	localparam logic [ANG_W-1:0] ANG_HALF = 9'd180;
	localparam logic [ANG_W-1:0] ANG_Q1   = 9'd90;
	localparam logic [ANG_W-1:0] ANG_Q2   = 9'd180;
	localparam logic [ANG_W-1:0] ANG_Q3   = 9'd270;
	localparam logic [6:0]       QTR      = 7'd90;
	localparam logic [PROD_W:0]  RND_HALF = (PROD_W+1)'(32768);
	localparam logic signed [SUM_W-1:0] OMAX = SUM_W'(2**(OUT_W-1) - 1);
	localparam logic signed [SUM_W-1:0] OMIN = -(SUM_W'(2**(OUT_W-1)));

	typedef struct packed {
		logic signed [CRD_W-1:0] cx;
		logic signed [CRD_W-1:0] cy;
		logic signed [CRD_W-1:0] dx;
		logic signed [CRD_W-1:0] dy;
		logic                    upper;
		logic [1:0]              st;
		logic [LEN_W-1:0]        r1;
		logic [2*LEN_W-1:0]      r1sq;
		logic signed [NA_W-1:0]  na;
		logic                    xneg;
		logic                    yneg;
		logic [ROOT_W-1:0]       span;
		logic signed [LEN_W:0]   a;
		logic [LEN_W:0]          h;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] cx;
		logic signed [OUT_W-1:0] cy;
		logic signed [OUT_W-1:0] jx;
		logic signed [OUT_W-1:0] jy;
		logic [1:0]              st;
	} out_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > OMAX)
			r = OMAX[OUT_W-1:0];
		else if (v < OMIN)
			r = OMIN[OUT_W-1:0];
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

	logic [LEN_W-1:0] crank_q, coupler_q, rocker_q, ground_q;
	logic             en, take;
	logic [1:0]       cnt_q;
	out_t             buf0_q, buf1_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18;

	logic [ANG_W-1:0]  ang_s1;
	logic [TRIG_W-1:0] smag_s2, cmag_s2;
	logic              sneg_s2, cneg_s2, upper_s2;
	logic [PROD_W-1:0] pc_s3, ps_s3;
	logic              sneg_s3, cneg_s3, upper_s3;
	item_t             it_s4, it_s5, it_s6, it_s7, it_s8, it_s9, it_s10;
	item_t             it_s11, it_s12, it_s13, it_s14, it_s15, it_s16, it_s17;
	logic signed [LEN_W:0] dif_s5;
	logic [LEN_W:0]    sum_s5;
	logic [SQR_W-1:0]  dxsq_s6, dysq_s6, difsq_s6, sumsq_s6;
	logic [2*LEN_W-1:0] r1sq_s6, r2sq_s6;
	logic [SQR_W-1:0]  d2_s7, lo_s7, hi_s7, d2_s8;
	logic signed [NA_W-1:0] nb_s7;
	div_t              dvb_s10, dvx_s17, dvy_s17;
	logic [2*LEN_W-1:0] asq_s12;
	sq_t               sqc_s13;
	logic signed [PM_W-1:0] adx_s15, hdy_s15, ady_s15, hdx_s15;
	logic signed [NX_W-1:0] nx_s16, ny_s16;
	out_t              res_s18;

	logic [1:0]        quad;
	logic [ANG_W-1:0]  base;
	logic [6:0]        rem;
	logic [TRIG_W-1:0] lut_a, lut_b;
	item_t             it4_d, it5_d, it7_d, it8_d, it9_d, it10_d, it11_d, it14_d, it17_d;
	logic [PROD_W:0]   rcx, rcy;
	logic signed [PM_W-1:0] dxsq_p, dysq_p, difsq_p;
	logic signed [NA_W-1:0] absna;
	logic [LEN_W-1:0]  amag;
	logic signed [2*LEN_W+1:0] asq_p;
	logic signed [NX_W-1:0] absnx, absny;
	logic signed [SUM_W-1:0] exs, eys, cxw, cyw;
	out_t              res_d;

	sq_t  sa [SQ_CELLS+1];
	sq_t  sc [SQ_CELLS+1];
	div_t db [DIV_CELLS+1];
	div_t dx_c [DIV_CELLS+1];
	div_t dy_c [DIV_CELLS+1];
	item_t sa_it_q [SQ_CELLS];
	item_t sc_it_q [SQ_CELLS];
	item_t db_it_q [DIV_CELLS];
	item_t dd_it_q [DIV_CELLS];
	logic [SQ_CELLS-1:0]  sa_v_q, sc_v_q;
	logic [DIV_CELLS-1:0] db_v_q, dd_v_q;

	assign en          = cnt_q != 2'd2;
	assign take        = angle_valid && en;
	assign angle_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crank_q   <= '0;
			coupler_q <= '0;
			rocker_q  <= '0;
			ground_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRANK:   crank_q   <= cfg_data;
				REG_COUPLER: coupler_q <= cfg_data;
				REG_ROCKER:  rocker_q  <= cfg_data;
				REG_GROUND:  ground_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ang_s1 >= ANG_Q3) begin
			quad = 2'd3;
			base = ANG_Q3;
		end else if (ang_s1 >= ANG_Q2) begin
			quad = 2'd2;
			base = ANG_Q2;
		end else if (ang_s1 >= ANG_Q1) begin
			quad = 2'd1;
			base = ANG_Q1;
		end else begin
			quad = 2'd0;
			base = '0;
		end
		rem   = 7'(ang_s1 - base);
		lut_a = sin_lut(rem);
		lut_b = sin_lut(QTR - rem);
	end

	always_comb begin
		rcx          = {1'b0, pc_s3} + RND_HALF;
		rcy          = {1'b0, ps_s3} + RND_HALF;
		it4_d        = '0;
		it4_d.cx     = cneg_s3 ? -$signed({1'b0, rcx[16+LEN_W:16]})
		                       : $signed({1'b0, rcx[16+LEN_W:16]});
		it4_d.cy     = sneg_s3 ? -$signed({1'b0, rcy[16+LEN_W:16]})
		                       : $signed({1'b0, rcy[16+LEN_W:16]});
		it4_d.upper  = upper_s3;
	end

	always_comb begin
		it5_d    = it_s4;
		it5_d.dx = $signed({2'b00, ground_q}) - it_s4.cx;
		it5_d.dy = -it_s4.cy;
		it5_d.r1 = coupler_q;
	end

	always_comb begin
		dxsq_p  = it_s5.dx * it_s5.dx;
		dysq_p  = it_s5.dy * it_s5.dy;
		difsq_p = PM_W'(dif_s5) * PM_W'(dif_s5);
	end

	always_comb begin
		it7_d      = it_s6;
		it7_d.r1sq = r1sq_s6;
	end

	always_comb begin
		it8_d    = it_s7;
		it8_d.na = nb_s7 + $signed({1'b0, d2_s7});
		if (d2_s7 == '0)
			it8_d.st = ST_COINCIDENT;
		else if (d2_s7 < lo_s7 || d2_s7 > hi_s7)
			it8_d.st = ST_NO_MEET;
		else
			it8_d.st = ST_SOLVED;
	end

	always_comb begin
		it9_d      = sa_it_q[SQ_CELLS-1];
		it9_d.span = sa[SQ_CELLS].root + ROOT_W'(sa[SQ_CELLS].rem > REM_W'(sa[SQ_CELLS].root));
	end

	always_comb begin
		absna       = it_s9.na[NA_W-1] ? -it_s9.na : it_s9.na;
		it10_d      = it_s9;
		it10_d.xneg = it_s9.na[NA_W-1];
	end

	always_comb begin
		amag      = (db[DIV_CELLS].q > DIV_N_W'(db_it_q[DIV_CELLS-1].r1))
		            ? db_it_q[DIV_CELLS-1].r1 : db[DIV_CELLS].q[LEN_W-1:0];
		it11_d    = db_it_q[DIV_CELLS-1];
		it11_d.a  = db_it_q[DIV_CELLS-1].xneg ? -$signed({1'b0, amag})
		                                      : $signed({1'b0, amag});
		asq_p     = it_s11.a * it_s11.a;
	end

	always_comb begin
		it14_d   = sc_it_q[SQ_CELLS-1];
		it14_d.h = (LEN_W+1)'(sc[SQ_CELLS].root
		           + ROOT_W'(sc[SQ_CELLS].rem > REM_W'(sc[SQ_CELLS].root)));
		absnx    = nx_s16[NX_W-1] ? -nx_s16 : nx_s16;
		absny    = ny_s16[NX_W-1] ? -ny_s16 : ny_s16;
	end

	always_comb begin
		it17_d      = it_s16;
		it17_d.xneg = nx_s16[NX_W-1];
		it17_d.yneg = ny_s16[NX_W-1];
	end

	always_comb begin
		exs = dd_it_q[DIV_CELLS-1].xneg ? -$signed({2'b00, dx_c[DIV_CELLS].q})
		                                : $signed({2'b00, dx_c[DIV_CELLS].q});
		eys = dd_it_q[DIV_CELLS-1].yneg ? -$signed({2'b00, dy_c[DIV_CELLS].q})
		                                : $signed({2'b00, dy_c[DIV_CELLS].q});
		cxw = {{(SUM_W-CRD_W){dd_it_q[DIV_CELLS-1].cx[CRD_W-1]}}, dd_it_q[DIV_CELLS-1].cx};
		cyw = {{(SUM_W-CRD_W){dd_it_q[DIV_CELLS-1].cy[CRD_W-1]}}, dd_it_q[DIV_CELLS-1].cy};
		res_d.cx = sat_out(cxw);
		res_d.cy = sat_out(cyw);
		res_d.st = dd_it_q[DIV_CELLS-1].st;
		if (dd_it_q[DIV_CELLS-1].st == ST_SOLVED) begin
			res_d.jx = sat_out(cxw + exs);
			res_d.jy = sat_out(cyw + eys);
		end else begin
			res_d.jx = '0;
			res_d.jy = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			{v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18} <= '0;
			sa_v_q <= '0;
			sc_v_q <= '0;
			db_v_q <= '0;
			dd_v_q <= '0;
		end else if (en) begin
			v_s1   <= take;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			sa_v_q <= {sa_v_q[SQ_CELLS-2:0], v_s8};
			v_s9   <= sa_v_q[SQ_CELLS-1];
			v_s10  <= v_s9;
			db_v_q <= {db_v_q[DIV_CELLS-2:0], v_s10};
			v_s11  <= db_v_q[DIV_CELLS-1];
			v_s12  <= v_s11;
			v_s13  <= v_s12;
			sc_v_q <= {sc_v_q[SQ_CELLS-2:0], v_s13};
			v_s14  <= sc_v_q[SQ_CELLS-1];
			v_s15  <= v_s14;
			v_s16  <= v_s15;
			v_s17  <= v_s16;
			dd_v_q <= {dd_v_q[DIV_CELLS-2:0], v_s17};
			v_s18  <= dd_v_q[DIV_CELLS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1   <= (angle_deg >= ANG_FULL) ? angle_deg - ANG_FULL : angle_deg;

			smag_s2  <= quad[0] ? lut_b : lut_a;
			cmag_s2  <= quad[0] ? lut_a : lut_b;
			sneg_s2  <= quad[1];
			cneg_s2  <= quad[1] ^ quad[0];
			upper_s2 <= ang_s1 <= ANG_HALF;

			pc_s3    <= crank_q * cmag_s2;
			ps_s3    <= crank_q * smag_s2;
			sneg_s3  <= sneg_s2;
			cneg_s3  <= cneg_s2;
			upper_s3 <= upper_s2;

			it_s4    <= it4_d;

			it_s5    <= it5_d;
			dif_s5   <= $signed({1'b0, coupler_q}) - $signed({1'b0, rocker_q});
			sum_s5   <= {1'b0, coupler_q} + {1'b0, rocker_q};

			it_s6    <= it_s5;
			dxsq_s6  <= $unsigned(dxsq_p);
			dysq_s6  <= $unsigned(dysq_p);
			difsq_s6 <= $unsigned(difsq_p);
			sumsq_s6 <= SQR_W'(sum_s5 * sum_s5);
			r1sq_s6  <= it_s5.r1 * it_s5.r1;
			r2sq_s6  <= rocker_q * rocker_q;

			it_s7      <= it7_d;
			d2_s7      <= dxsq_s6 + dysq_s6;
			lo_s7      <= difsq_s6;
			hi_s7      <= sumsq_s6;
			nb_s7      <= $signed({{(NA_W-2*LEN_W){1'b0}}, r1sq_s6})
			            - $signed({{(NA_W-2*LEN_W){1'b0}}, r2sq_s6});

			it_s8    <= it8_d;
			d2_s8    <= d2_s7;

			it_s9    <= it9_d;

			it_s10   <= it10_d;
			dvb_s10  <= '{r: '0, n: DIV_N_W'(absna) + DIV_N_W'(it_s9.span), q: '0,
			              d: {it_s9.span, 1'b0}};

			it_s11   <= it11_d;

			it_s12   <= it_s11;
			asq_s12  <= asq_p[2*LEN_W-1:0];

			it_s13   <= it_s12;
			sqc_s13  <= '{rem: '0, rad: RAD_W'(it_s12.r1sq - asq_s12), root: '0};

			it_s14   <= it14_d;

			it_s15   <= it_s14;
			adx_s15  <= it_s14.a * it_s14.dx;
			hdy_s15  <= $signed({1'b0, it_s14.h}) * it_s14.dy;
			ady_s15  <= it_s14.a * it_s14.dy;
			hdx_s15  <= $signed({1'b0, it_s14.h}) * it_s14.dx;

			it_s16   <= it_s15;
			nx_s16   <= it_s15.upper ? NX_W'(adx_s15) - NX_W'(hdy_s15)
			                         : NX_W'(adx_s15) + NX_W'(hdy_s15);
			ny_s16   <= it_s15.upper ? NX_W'(ady_s15) + NX_W'(hdx_s15)
			                         : NX_W'(ady_s15) - NX_W'(hdx_s15);

			it_s17   <= it17_d;
			dvx_s17  <= '{r: '0, n: DIV_N_W'(absnx) + DIV_N_W'(it_s16.span >> 1), q: '0,
			              d: {1'b0, it_s16.span}};
			dvy_s17  <= '{r: '0, n: DIV_N_W'(absny) + DIV_N_W'(it_s16.span >> 1), q: '0,
			              d: {1'b0, it_s16.span}};

			res_s18  <= res_d;

			sa_it_q[0] <= it_s8;
			sc_it_q[0] <= it_s13;
			db_it_q[0] <= it_s10;
			dd_it_q[0] <= it_s17;
			for (int i = 1; i < SQ_CELLS; i++) begin
				sa_it_q[i] <= sa_it_q[i-1];
				sc_it_q[i] <= sc_it_q[i-1];
			end
			for (int i = 1; i < DIV_CELLS; i++) begin
				db_it_q[i] <= db_it_q[i-1];
				dd_it_q[i] <= dd_it_q[i-1];
			end
		end
	end

	assign sa[0]   = '{rem: '0, rad: RAD_W'(d2_s8), root: '0};
	assign sc[0]   = sqc_s13;
	assign db[0]   = dvb_s10;
	assign dx_c[0] = dvx_s17;
	assign dy_c[0] = dvy_s17;

	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
		fbl_sqrt_cell u_dist (.clk(clk), .en(en), .d_in(sa[i]), .d_out(sa[i+1]));
		fbl_sqrt_cell u_hgt  (.clk(clk), .en(en), .d_in(sc[i]), .d_out(sc[i+1]));
	end

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		fbl_div_cell u_chord (.clk(clk), .en(en), .d_in(db[i]),   .d_out(db[i+1]));
		fbl_div_cell u_ex    (.clk(clk), .en(en), .d_in(dx_c[i]), .d_out(dx_c[i+1]));
		fbl_div_cell u_ey    (.clk(clk), .en(en), .d_in(dy_c[i]), .d_out(dy_c[i+1]));
	end

	logic push, pop;
	assign push = en && v_s18;
	assign pop  = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cnt_q)
				2'd0: cnt_q <= push ? 2'd1 : 2'd0;
				2'd1: cnt_q <= (push && !pop) ? 2'd2 : ((pop && !push) ? 2'd0 : 2'd1);
				2'd2: cnt_q <= pop ? 2'd1 : 2'd2;
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 2'd0 && push)
			buf0_q <= res_s18;
		else if (cnt_q == 2'd1 && push && pop)
			buf0_q <= res_s18;
		else if (cnt_q == 2'd1 && push)
			buf1_q <= res_s18;
		else if (cnt_q == 2'd2 && pop)
			buf0_q <= buf1_q;
	end

	assign result_valid = cnt_q != 2'd0;
	assign crank_x      = buf0_q.cx;
	assign crank_y      = buf0_q.cy;
	assign joint_x      = buf0_q.jx;
	assign joint_y      = buf0_q.jy;
	assign status       = buf0_q.st;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("output buffer count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && result_stall) |=> cnt_q == 2'd2)
		else $error("full output buffer lost an entry while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1 && !result_stall && !push) |=> !result_valid)
		else $error("output buffer did not drain after transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && it_s9.st == ST_SOLVED) |-> it_s9.span != '0)
		else $error("zero pivot distance on a solved item");

endmodule

`default_nettype wire
